[sv/cps_pkg.sv]
`default_nettype none

package cps_pkg;

    // Default width of the millisecond down-counter.
    localparam int CPS_COUNTER_BITS = 13;

    // Widths of the configuration registers and the configuration port.
    localparam int PULSE_W  = 13;
    localparam int PRE_W    = 13;
    localparam int GAP_W    = 10;
    localparam int RETRY_W  = 10;
    localparam int HOLD_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_RING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSE_RETRY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLD = 3'd4;

    // Register values after reset.
    localparam logic [PULSE_W-1:0] PULSE_RST = 13'd200;
    localparam logic [PRE_W-1:0]   PRE_RST   = 13'd1500;
    localparam logic [GAP_W-1:0]   GAP_RST   = 10'd30;
    localparam logic [RETRY_W-1:0] RETRY_RST = 10'd100;
    localparam logic [HOLD_W-1:0]  HOLD_RST  = 13'd1000;

    // Input command codes.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RING  = 2'd1;
    localparam logic [1:0] MODE_OFF   = 2'd2;
    localparam logic [1:0] MODE_ABORT = 2'd3;

    // Sequence status codes.
    localparam logic [1:0] STATUS_IDLE = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_OK   = 2'd2;
    localparam logic [1:0] STATUS_FAIL = 2'd3;

    // Fault cause codes.
    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_ENERGY   = 2'd1;
    localparam logic [1:0] FAULT_MISMATCH = 2'd2;
    localparam logic [1:0] FAULT_ABORT    = 2'd3;

    // Drive pin masks: bit 0 stage 1, bit 1 stage 2, bit 2 trigger.
    localparam logic [2:0] PIN_NONE = 3'b000;
    localparam logic [2:0] PIN_S1   = 3'b001;
    localparam logic [2:0] PIN_S2   = 3'b010;
    localparam logic [2:0] PIN_TR   = 3'b100;

    // Sequencer phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_RETRY = 9'b000000010,
        PH_PRE   = 9'b000000100,
        PH_GAP1  = 9'b000001000,
        PH_GAP2  = 9'b000010000,
        PH_PULSE = 9'b000100000,
        PH_HOLD  = 9'b001000000,
        PH_GAP3  = 9'b010000000,
        PH_FINAL = 9'b100000000
    } phase_t;

endpackage

`default_nettype wire

[sv/cps_in_if.sv]
`default_nettype none

// Command channel: one beat per tick or command.
interface cps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       energy_sense;
    logic [2:0] pin_readback;

    modport source (output valid, output mode, output energy_sense,
                    output pin_readback, input ready);
    modport sink (input valid, input mode, input energy_sense,
                  input pin_readback, output ready);
endinterface

`default_nettype wire

[sv/cps_out_if.sv]
`default_nettype none

// Result channel: one beat per accepted command beat.
interface cps_out_if;
    logic       valid;
    logic       ready;
    logic       stage1_drive;
    logic       stage2_drive;
    logic       trigger_drive;
    logic [1:0] seq_status;
    logic [1:0] fault_cause;

    modport source (output valid, output stage1_drive, output stage2_drive,
                    output trigger_drive, output seq_status, output fault_cause,
                    input ready);
    modport sink (input valid, input stage1_drive, input stage2_drive,
                  input trigger_drive, input seq_status, input fault_cause,
                  output ready);
endinterface

`default_nettype wire

[sv/cps_cfg_if.sv]
`default_nettype none

// Configuration write channel.
interface cps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cps_pkg::CFG_IDX_W-1:0]  index;
    logic [cps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/chime_power_sequencer_unit.sv]
// Chime power sequencer.
// The cmd channel carries one beat per millisecond tick or command (ring,
// power off, abort) together with the sampled energy-ready level and the pad
// readback of the three drives. Every accepted cmd beat produces exactly one
// result beat with the commanded drive levels, the sequence status and the
// fault cause.
// The result of a beat is registered and is valid in the cycle after it
// is accepted. Throughput is one beat per cycle; the only limit is the single
// output register, and cmd stays ready while that register is empty or is
// being drained in the same cycle.
// When the receiver stalls, the result holds in the output register and cmd
// stops accepting until it is taken; no beat is lost or repeated.
// The cfg channel is always ready and writes one timing register per beat;
// writes are meant to happen while the sequencer is idle.
// Reset returns the drive state low, the status to idle with no fault and the
// timing registers to their default values.
`default_nettype none

module chime_power_sequencer_unit #(
    parameter int COUNTER_BITS = cps_pkg::CPS_COUNTER_BITS
) (
    input  wire         clk,
    input  wire         rst_n,
    cps_in_if.sink      cmd,
    cps_out_if.source   result,
    cps_cfg_if.sink     cfg
);

    localparam int CMP_W = (COUNTER_BITS > cps_pkg::CFG_DATA_W) ?
                           COUNTER_BITS : cps_pkg::CFG_DATA_W;
    localparam logic [CMP_W-1:0] CNT_TOP = CMP_W'({COUNTER_BITS{1'b1}});

    // Timing registers.
    logic [cps_pkg::PULSE_W-1:0] pulse_reg;
    logic [cps_pkg::PRE_W-1:0]   pre_reg;
    logic [cps_pkg::GAP_W-1:0]   gap_reg;
    logic [cps_pkg::RETRY_W-1:0] retry_reg;
    logic [cps_pkg::HOLD_W-1:0]  hold_reg;

    // Sequencer state.
    cps_pkg::phase_t           phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]   cnt_reg, cnt_next;
    logic [2:0]                drive_reg, drive_next;
    logic [2:0]                chk_reg, chk_next;
    logic                      failed_reg, failed_next;
    logic [1:0]                status_reg, status_next;
    logic [1:0]                fault_reg, fault_next;

    // Output register.
    logic       out_valid_reg;
    logic [2:0] out_drive_reg;
    logic [1:0] out_status_reg;
    logic [1:0] out_fault_reg;

    logic cmd_fire;

    // Wait lengths saturated to the counter width.
    logic [COUNTER_BITS-1:0] pulse_sat, pre_sat, gap_sat, retry_sat, hold_sat;

    // Combinational decision terms.
    logic                    alive;
    logic                    fin;
    logic [1:0]              fin_cause;
    logic                    want;
    logic                    got;
    logic [COUNTER_BITS-1:0] cnt_dec;

    assign cfg.ready    = 1'b1;
    assign cmd.ready    = !out_valid_reg || result.ready;
    assign cmd_fire     = cmd.valid && cmd.ready;

    // Saturate each configured wait to the largest counter value.
    always_comb
    begin
        pulse_sat = (CMP_W'(pulse_reg) > CNT_TOP) ? COUNTER_BITS'(CNT_TOP) :
                    COUNTER_BITS'(CMP_W'(pulse_reg));
        pre_sat   = (CMP_W'(pre_reg) > CNT_TOP) ? COUNTER_BITS'(CNT_TOP) :
                    COUNTER_BITS'(CMP_W'(pre_reg));
        gap_sat   = (CMP_W'(gap_reg) > CNT_TOP) ? COUNTER_BITS'(CNT_TOP) :
                    COUNTER_BITS'(CMP_W'(gap_reg));
        retry_sat = (CMP_W'(retry_reg) > CNT_TOP) ? COUNTER_BITS'(CNT_TOP) :
                    COUNTER_BITS'(CMP_W'(retry_reg));
        hold_sat  = (CMP_W'(hold_reg) > CNT_TOP) ? COUNTER_BITS'(CNT_TOP) :
                    COUNTER_BITS'(CMP_W'(hold_reg));
    end

    // Next state for one accepted beat: abort, then the pending readback
    // check, then the command or tick.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        drive_next  = drive_reg;
        chk_next    = chk_reg;
        failed_next = failed_reg;
        status_next = status_reg;
        fault_next  = fault_reg;
        alive       = 1'b1;
        fin         = 1'b0;
        fin_cause   = cps_pkg::FAULT_NONE;
        want        = |(drive_reg & chk_reg);
        got         = |(cmd.pin_readback & chk_reg);
        cnt_dec     = (cnt_reg != '0) ? cnt_reg - COUNTER_BITS'(1) : cnt_reg;

        if (cmd.mode == cps_pkg::MODE_ABORT)
        begin
            fin       = 1'b1;
            fin_cause = cps_pkg::FAULT_ABORT;
        end
        else
        begin
            // Readback check of the drive changed by the previous beat.
            if (chk_reg != cps_pkg::PIN_NONE)
            begin
                chk_next = cps_pkg::PIN_NONE;
                if (want != got)
                begin
                    if (want)
                    begin
                        fin       = 1'b1;
                        fin_cause = cps_pkg::FAULT_MISMATCH;
                        alive     = 1'b0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                        fault_next  = cps_pkg::FAULT_MISMATCH;
                    end
                end
            end

            if (alive)
            begin
                case (phase_reg)
                    cps_pkg::PH_FINAL:
                    begin
                        phase_next  = cps_pkg::PH_IDLE;
                        cnt_next    = '0;
                        status_next = failed_next ? cps_pkg::STATUS_FAIL :
                                                    cps_pkg::STATUS_OK;
                    end
                    cps_pkg::PH_IDLE:
                    begin
                        if (cmd.mode == cps_pkg::MODE_RING)
                        begin
                            failed_next = 1'b0;
                            fault_next  = cps_pkg::FAULT_NONE;
                            drive_next  = cps_pkg::PIN_NONE;
                            if (cmd.energy_sense)
                            begin
                                phase_next = cps_pkg::PH_PRE;
                                cnt_next   = pre_sat;
                            end
                            else
                            begin
                                phase_next = cps_pkg::PH_RETRY;
                                cnt_next   = retry_sat;
                            end
                        end
                        else if (cmd.mode == cps_pkg::MODE_OFF)
                        begin
                            failed_next = 1'b0;
                            fault_next  = cps_pkg::FAULT_NONE;
                            drive_next  = cps_pkg::PIN_NONE;
                            chk_next    = cps_pkg::PIN_TR;
                            phase_next  = cps_pkg::PH_HOLD;
                            cnt_next    = hold_sat;
                        end
                    end
                    default:
                    begin
                        if (cmd.mode == cps_pkg::MODE_TICK)
                        begin
                            cnt_next = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                case (phase_reg)
                                    cps_pkg::PH_RETRY:
                                    begin
                                        if (cmd.energy_sense)
                                        begin
                                            phase_next = cps_pkg::PH_PRE;
                                            cnt_next   = pre_sat;
                                        end
                                        else
                                        begin
                                            fin       = 1'b1;
                                            fin_cause = cps_pkg::FAULT_ENERGY;
                                        end
                                    end
                                    cps_pkg::PH_PRE:
                                    begin
                                        drive_next = drive_reg | cps_pkg::PIN_S1;
                                        chk_next   = cps_pkg::PIN_S1;
                                        phase_next = cps_pkg::PH_GAP1;
                                        cnt_next   = gap_sat;
                                    end
                                    cps_pkg::PH_GAP1:
                                    begin
                                        drive_next = drive_reg | cps_pkg::PIN_S2;
                                        chk_next   = cps_pkg::PIN_S2;
                                        phase_next = cps_pkg::PH_GAP2;
                                        cnt_next   = gap_sat;
                                    end
                                    cps_pkg::PH_GAP2:
                                    begin
                                        drive_next = drive_reg | cps_pkg::PIN_TR;
                                        chk_next   = cps_pkg::PIN_TR;
                                        phase_next = cps_pkg::PH_PULSE;
                                        cnt_next   = pulse_sat;
                                    end
                                    cps_pkg::PH_PULSE:
                                    begin
                                        drive_next = drive_reg & ~cps_pkg::PIN_TR;
                                        chk_next   = cps_pkg::PIN_TR;
                                        phase_next = cps_pkg::PH_HOLD;
                                        cnt_next   = hold_sat;
                                    end
                                    cps_pkg::PH_HOLD:
                                    begin
                                        drive_next = drive_reg & ~cps_pkg::PIN_S2;
                                        chk_next   = cps_pkg::PIN_S2;
                                        phase_next = cps_pkg::PH_GAP3;
                                        cnt_next   = gap_sat;
                                    end
                                    cps_pkg::PH_GAP3:
                                    begin
                                        drive_next = drive_reg & ~cps_pkg::PIN_S1;
                                        chk_next   = cps_pkg::PIN_S1;
                                        phase_next = cps_pkg::PH_FINAL;
                                        cnt_next   = '0;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
        end

        // Failure that shuts the sequence down: all drives low.
        if (fin)
        begin
            drive_next  = cps_pkg::PIN_NONE;
            chk_next    = cps_pkg::PIN_NONE;
            cnt_next    = '0;
            phase_next  = cps_pkg::PH_IDLE;
            status_next = cps_pkg::STATUS_FAIL;
            fault_next  = fin_cause;
            failed_next = 1'b1;
        end
    end

    // Timing registers, written by the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= cps_pkg::PULSE_RST;
            pre_reg   <= cps_pkg::PRE_RST;
            gap_reg   <= cps_pkg::GAP_RST;
            retry_reg <= cps_pkg::RETRY_RST;
            hold_reg  <= cps_pkg::HOLD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                cps_pkg::REG_PULSE_LENGTH: pulse_reg <= cfg.data[cps_pkg::PULSE_W-1:0];
                cps_pkg::REG_PRE_RING:     pre_reg   <= cfg.data[cps_pkg::PRE_W-1:0];
                cps_pkg::REG_STAGE_GAP:    gap_reg   <= cfg.data[cps_pkg::GAP_W-1:0];
                cps_pkg::REG_SENSE_RETRY:  retry_reg <= cfg.data[cps_pkg::RETRY_W-1:0];
                cps_pkg::REG_RELEASE_HOLD: hold_reg  <= cfg.data[cps_pkg::HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer state, updated on every accepted cmd beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cps_pkg::PH_IDLE;
            cnt_reg    <= '0;
            drive_reg  <= cps_pkg::PIN_NONE;
            chk_reg    <= cps_pkg::PIN_NONE;
            failed_reg <= 1'b0;
            status_reg <= cps_pkg::STATUS_IDLE;
            fault_reg  <= cps_pkg::FAULT_NONE;
        end
        else if (cmd_fire)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            drive_reg  <= drive_next;
            chk_reg    <= chk_next;
            failed_reg <= failed_next;
            status_reg <= status_next;
            fault_reg  <= fault_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, captured with the beat that produced it.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            out_drive_reg  <= drive_next;
            out_status_reg <= (phase_next != cps_pkg::PH_IDLE) ?
                              cps_pkg::STATUS_BUSY : status_next;
            out_fault_reg  <= fault_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.stage1_drive  = out_drive_reg[0];
    assign result.stage2_drive  = out_drive_reg[1];
    assign result.trigger_drive = out_drive_reg[2];
    assign result.seq_status    = out_status_reg;
    assign result.fault_cause   = out_fault_reg;

endmodule

`default_nettype wire
